@@ src/qcs_pkg.sv @@
package qcs_pkg;

    localparam int CHANNELS = 2;
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int COUNT_W    = 32;
    localparam int TIME_W     = 32;
    localparam int INTERVAL_W = 16;
    localparam int FRAC_W     = 16;

    localparam logic [INTERVAL_W-1:0] SPEED_INTERVAL_RESET = INTERVAL_W'(50);

    // Dividend is |delta| scaled by 2^FRAC_W
    localparam int DIVIDEND_W = COUNT_W + FRAC_W;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [1:0] STEP_FWD = 2'd1;
    localparam logic [1:0] STEP_REV = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic [1:0]        pins;    // bit0 = A, bit1 = B
        logic [1:0]        phase;
        logic [TIME_W-1:0] time_ms;
    } t_sample;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [TIME_W-1:0]     divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic {
        BK_IDLE,
        BK_DIV
    } t_back_state;

    function automatic logic [1:0] pins_to_phase(input logic [1:0] pins);
        logic [1:0] ph;
        case (pins)
            2'b00:   ph = 2'd0;
            2'b01:   ph = 2'd1;
            2'b11:   ph = 2'd2;
            2'b10:   ph = 2'd3;
            default: ph = 2'd0;
        endcase
        return ph;
    endfunction

endpackage

@@ src/qcs_if.sv @@
interface qcs_in_if;
    logic        valid;
    logic        ready;
    logic        channel;
    logic        pin_a;
    logic        pin_b;
    logic [31:0] time_ms;

    modport source (output valid, channel, pin_a, pin_b, time_ms, input ready);
    modport sink   (input valid, channel, pin_a, pin_b, time_ms, output ready);
endinterface

interface qcs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position_count;
    logic signed [31:0] speed;
    logic               speed_updated;

    modport source (output valid, position_count, speed, speed_updated, input ready);
    modport sink   (input valid, position_count, speed, speed_updated, output ready);
endinterface

@@ src/qcs_front.sv @@
module qcs_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    qcs_in_if.sink           i_in,
    output logic             o_q_valid,
    output qcs_pkg::t_sample o_q_item,
    input  logic             i_q_pop
);

    qcs_pkg::t_sample r_q [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_fill;

    qcs_pkg::t_sample w_item;
    logic             w_push;

    always_comb begin
        // a single channel folds every channel number onto entry zero
        w_item.ch      = (qcs_pkg::CHANNELS == 1) ? '0 : qcs_pkg::CH_W'(i_in.channel);
        w_item.pins    = {i_in.pin_b, i_in.pin_a};
        w_item.phase   = qcs_pkg::pins_to_phase({i_in.pin_b, i_in.pin_a});
        w_item.time_ms = i_in.time_ms;
    end

    assign i_in.ready = (r_fill != 2'd2);
    assign w_push     = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_fill != 2'd0);
    assign o_q_item   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, i_q_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

@@ src/qcs_div.sv @@
module qcs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  qcs_pkg::t_div_req i_req,
    output qcs_pkg::t_div_rsp o_rsp
);

    logic                                r_busy;
    logic                                r_done;
    logic [qcs_pkg::DIV_CNT_W-1:0]       r_cnt;
    logic [qcs_pkg::TIME_W-1:0]          r_divisor;
    logic [qcs_pkg::TIME_W-1:0]          r_rem;
    logic [qcs_pkg::DIVIDEND_W-1:0]      r_quo;

    logic [qcs_pkg::TIME_W:0]            w_rem_sh;
    logic [qcs_pkg::TIME_W:0]            w_rem_sub;
    logic                                w_bit;

    // restoring division, one quotient bit a cycle
    always_comb begin
        w_rem_sh  = {r_rem, r_quo[qcs_pkg::DIVIDEND_W-1]};
        w_rem_sub = w_rem_sh - {1'b0, r_divisor};
        w_bit     = (w_rem_sh >= {1'b0, r_divisor});
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_divisor <= i_req.divisor;
            r_rem     <= '0;
            r_quo     <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= w_bit ? w_rem_sub[qcs_pkg::TIME_W-1:0] : w_rem_sh[qcs_pkg::TIME_W-1:0];
            r_quo <= {r_quo[qcs_pkg::DIVIDEND_W-2:0], w_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= qcs_pkg::DIV_CNT_W'(qcs_pkg::DIV_STEPS - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - qcs_pkg::DIV_CNT_W'(1);
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

endmodule

@@ src/qcs_back.sv @@
module qcs_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [qcs_pkg::INTERVAL_W-1:0]     i_cfg_data,
    input  logic                               i_q_valid,
    input  qcs_pkg::t_sample                   i_q_item,
    output logic                               o_q_pop,
    output qcs_pkg::t_div_req                  o_div_req,
    input  qcs_pkg::t_div_rsp                  i_div_rsp,
    qcs_out_if.source                          o_out
);

    localparam int CW = qcs_pkg::COUNT_W;

    qcs_pkg::t_back_state             r_state;
    qcs_pkg::t_back_state             n_state;

    logic [qcs_pkg::INTERVAL_W-1:0]   r_interval;
    logic [CW-1:0]                    r_count     [qcs_pkg::CHANNELS];
    logic [1:0]                       r_phase     [qcs_pkg::CHANNELS];
    logic [1:0]                       r_pins      [qcs_pkg::CHANNELS];
    logic [qcs_pkg::TIME_W-1:0]       r_upd_time  [qcs_pkg::CHANNELS];
    logic [CW-1:0]                    r_upd_count [qcs_pkg::CHANNELS];
    logic [CW-1:0]                    r_speed     [qcs_pkg::CHANNELS];

    logic [qcs_pkg::CH_W-1:0]         r_cur_ch;
    logic [CW-1:0]                    r_cur_count;
    logic                             r_neg;

    logic                             r_out_valid;
    logic [CW-1:0]                    r_out_count;
    logic [CW-1:0]                    r_out_speed;
    logic                             r_out_upd;

    logic                             w_out_free;
    logic [qcs_pkg::CH_W-1:0]         w_ch;
    logic                             w_pins_chg;
    logic [1:0]                       w_diff;
    logic [CW-1:0]                    w_new_count;
    logic [qcs_pkg::TIME_W-1:0]       w_dt;
    logic                             w_need_upd;
    logic [CW-1:0]                    w_delta;
    logic [CW-1:0]                    w_mag;
    logic                             w_pop;
    logic                             w_finish;
    logic [qcs_pkg::DIVIDEND_W-1:0]   w_quo;
    logic [CW-1:0]                    w_sat;

    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        w_ch       = i_q_item.ch;
        w_pins_chg = (i_q_item.pins != r_pins[w_ch]);
        w_diff     = i_q_item.phase - r_phase[w_ch];
        w_new_count = r_count[w_ch];
        if (w_pins_chg && w_diff == qcs_pkg::STEP_FWD) begin
            w_new_count = r_count[w_ch] + CW'(1);
        end else if (w_pins_chg && w_diff == qcs_pkg::STEP_REV) begin
            w_new_count = r_count[w_ch] - CW'(1);
        end
        w_dt       = i_q_item.time_ms - r_upd_time[w_ch];
        w_need_upd = (w_dt > {{(qcs_pkg::TIME_W - qcs_pkg::INTERVAL_W){1'b0}}, r_interval});
        w_delta    = w_new_count - r_upd_count[w_ch];
        w_mag      = w_delta[CW-1] ? (CW'(0) - w_delta) : w_delta;
    end

    // truncate toward zero on the magnitude, then saturate to 32 bits
    always_comb begin
        w_quo = i_div_rsp.quotient;
        if (!r_neg) begin
            if (w_quo[qcs_pkg::DIVIDEND_W-1:CW-1] != '0) begin
                w_sat = {1'b0, {(CW-1){1'b1}}};
            end else begin
                w_sat = w_quo[CW-1:0];
            end
        end else begin
            if (w_quo[qcs_pkg::DIVIDEND_W-1:CW] != '0
                || (w_quo[CW-1] && w_quo[CW-2:0] != '0)) begin
                w_sat = {1'b1, {(CW-1){1'b0}}};
            end else begin
                w_sat = CW'(0) - w_quo[CW-1:0];
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        w_pop    = 1'b0;
        w_finish = 1'b0;
        case (r_state)
            qcs_pkg::BK_IDLE: begin
                if (i_q_valid && w_out_free) begin
                    w_pop = 1'b1;
                    if (w_need_upd) begin
                        n_state = qcs_pkg::BK_DIV;
                    end
                end
            end
            qcs_pkg::BK_DIV: begin
                if (i_div_rsp.done && w_out_free) begin
                    w_finish = 1'b1;
                    n_state  = qcs_pkg::BK_IDLE;
                end
            end
            default: n_state = qcs_pkg::BK_IDLE;
        endcase
    end

    assign o_q_pop            = w_pop;
    assign o_div_req.start    = w_pop && w_need_upd;
    assign o_div_req.dividend = {w_mag, {qcs_pkg::FRAC_W{1'b0}}};
    assign o_div_req.divisor  = w_dt;

    assign o_out.valid          = r_out_valid;
    assign o_out.position_count = r_out_count;
    assign o_out.speed          = r_out_speed;
    assign o_out.speed_updated  = r_out_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= qcs_pkg::BK_IDLE;
            r_interval <= qcs_pkg::SPEED_INTERVAL_RESET;
            for (int i = 0; i < qcs_pkg::CHANNELS; i++) begin
                r_count[i]     <= '0;
                r_phase[i]     <= '0;
                r_pins[i]      <= '0;
                r_upd_time[i]  <= '0;
                r_upd_count[i] <= '0;
                r_speed[i]     <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_interval <= i_cfg_data;
            end
            if (w_pop) begin
                r_count[w_ch] <= w_new_count;
                if (w_pins_chg) begin
                    r_pins[w_ch]  <= i_q_item.pins;
                    r_phase[w_ch] <= i_q_item.phase;
                end
                if (w_need_upd) begin
                    r_upd_time[w_ch]  <= i_q_item.time_ms;
                    r_upd_count[w_ch] <= w_new_count;
                end
            end
            if (w_finish) begin
                r_speed[r_cur_ch] <= w_sat;
            end
            if ((w_pop && !w_need_upd) || w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && w_need_upd) begin
            r_cur_ch    <= w_ch;
            r_cur_count <= w_new_count;
            r_neg       <= w_delta[CW-1];
        end
        if (w_pop && !w_need_upd) begin
            r_out_count <= w_new_count;
            r_out_speed <= r_speed[w_ch];
            r_out_upd   <= 1'b0;
        end else if (w_finish) begin
            r_out_count <= r_cur_count;
            r_out_speed <= w_sat;
            r_out_upd   <= 1'b1;
        end
    end

endmodule

@@ src/quadrature_counter_with_speed_top.sv @@
// Path: a sample is registered in the front queue and then in the output register;
// a speed update adds the serial quotient (one bit a cycle) between the two.
// Throughput: one sample a cycle while the output is ready; a sample that triggers a
// speed update holds the back end while a 2-word queue takes input until it is full.
// Reset: synchronous, active low; counts, phases, speeds and update marks clear to zero
// and the speed interval returns to 50 ms.
module quadrature_counter_with_speed_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    qcs_in_if.sink      i_in,
    qcs_out_if.source   o_out
);

    logic              w_q_valid;
    qcs_pkg::t_sample  w_q_item;
    logic              w_q_pop;
    qcs_pkg::t_div_req w_div_req;
    qcs_pkg::t_div_rsp w_div_rsp;

    qcs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_q_pop)
    );

    qcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    qcs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_q_item),
        .o_q_pop    (w_q_pop),
        .o_div_req  (w_div_req),
        .i_div_rsp  (w_div_rsp),
        .o_out      (o_out)
    );

endmodule
